FILE: sv/rpi_pkg.sv
package rpi_pkg;

    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        CFG_NORMAL_X   = 3'd0,
        CFG_NORMAL_Y   = 3'd1,
        CFG_NORMAL_Z   = 3'd2,
        CFG_OFFSET     = 3'd3,
        CFG_TWO_SIDED  = 3'd4,
        CFG_COLOUR     = 3'd5
    } cfg_index_t;

    // The first member is the highest field, so origin_x sits in the lowest bits.
    typedef struct packed {
        logic signed [31:0] far_dist;
        logic signed [31:0] near_dist;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_x;
    } ray_t;

    // State carried from one divider cell to the next.
    typedef struct packed {
        logic        valid;
        logic        ok;
        logic        neg;
        logic        ovf;
        logic [49:0] rem;
        logic [49:0] dvs;
        logic [15:0] lo;
        logic [31:0] quo;
        ray_t        ray;
    } rpi_div_t;

endpackage

FILE: sv/rpi_div_cell.sv
module rpi_div_cell import rpi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  rpi_div_t d_in,
    output rpi_div_t d_out
);

    rpi_div_t    d_reg;
    rpi_div_t    d_next;
    logic [50:0] trial;
    logic [50:0] diff;
    logic        ge;

    // One restoring step: bring down the next dividend bit and try a subtraction.
    always_comb begin
        trial  = {d_in.rem, d_in.lo[15]};
        diff   = trial - {1'b0, d_in.dvs};
        ge     = (trial >= {1'b0, d_in.dvs});
        d_next = d_in;
        d_next.rem = ge ? diff[49:0] : trial[49:0];
        d_next.lo  = {d_in.lo[14:0], 1'b0};
        d_next.quo = {d_in.quo[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: sv/ray_plane_intersect.sv
// Ray against plane intersection test, one transaction per clock when unstalled.
// Pipeline: 38 register stages lie between the edge that accepts an input
// transaction and its result on m_tvalid.
// Throughput: one ray per cycle when nothing stalls; the 32-cell divider chain makes up most of the depth.
// The whole pipeline holds while a result waits on m_tready.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults: normal (0, 0, 1.0), offset 0, one-sided, colour 0.
module ray_plane_intersect import rpi_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // Ray input.
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_dist, far_dist
    input  logic [255:0] s_tdata,
    // Result output.
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance, point_x, point_y, point_z, hit_colour
    output logic [159:0] m_tdata,
    // hit
    output logic         m_tuser
);

    // Configuration registers.
    logic signed [17:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] offset_reg;
    logic               two_sided_reg;
    logic        [31:0] colour_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg        <= '0;
            ny_reg        <= '0;
            nz_reg        <= 18'sd65536;
            offset_reg    <= '0;
            two_sided_reg <= 1'b0;
            colour_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_NORMAL_X:  nx_reg        <= cfg_wdata[17:0];
                CFG_NORMAL_Y:  ny_reg        <= cfg_wdata[17:0];
                CFG_NORMAL_Z:  nz_reg        <= cfg_wdata[17:0];
                CFG_OFFSET:    offset_reg    <= cfg_wdata;
                CFG_TWO_SIDED: two_sided_reg <= cfg_wdata[0];
                CFG_COLOUR:    colour_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Every stage moves together; the output register is the last stage.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ray_t in_ray;
    assign in_ray = ray_t'(s_tdata);

    // Stage 1: the six products of the normal with direction and origin.
    logic               s1_valid_reg;
    ray_t               s1_ray_reg;
    logic signed [49:0] nd_x_reg, nd_y_reg, nd_z_reg;
    logic signed [49:0] no_x_reg, no_y_reg, no_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s1_ray_reg   <= in_ray;
            nd_x_reg     <= nx_reg * in_ray.dir_x;
            nd_y_reg     <= ny_reg * in_ray.dir_y;
            nd_z_reg     <= nz_reg * in_ray.dir_z;
            no_x_reg     <= nx_reg * in_ray.origin_x;
            no_y_reg     <= ny_reg * in_ray.origin_y;
            no_z_reg     <= nz_reg * in_ray.origin_z;
        end
    end

    // Stage 2: the denominator (Q20.32) and the numerator (Q21.32), both exact.
    logic               s2_valid_reg;
    ray_t               s2_ray_reg;
    logic signed [51:0] den_reg;
    logic signed [52:0] num_reg;
    logic signed [51:0] dot_o;

    assign dot_o = 52'(no_x_reg) + 52'(no_y_reg) + 52'(no_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
            s2_ray_reg   <= s1_ray_reg;
            den_reg      <= 52'(nd_x_reg) + 52'(nd_y_reg) + 52'(nd_z_reg);
            num_reg      <= 53'($signed({offset_reg, 16'd0})) - 53'(dot_o);
        end
    end

    // Stage 3: magnitudes, quotient sign, culling and the overflow check.
    // The quotient is floor(|num| * 2^16 / |den|); it reaches 2^32 exactly
    // when the top bits of |num| are not below |den|.
    logic [52:0] num_mag;
    logic [51:0] den_mag;
    rpi_div_t    div_first;
    rpi_div_t    div_head_reg;
    rpi_div_t    div_chain [0:DIV_STEPS];

    assign num_mag = num_reg[52] ? 53'(-num_reg) : 53'(num_reg);
    assign den_mag = den_reg[51] ? 52'(-den_reg) : 52'(den_reg);

    always_comb begin
        div_first.valid = s2_valid_reg;
        div_first.ok    = (den_reg != '0) && (two_sided_reg || den_reg[51]);
        div_first.neg   = num_reg[52] ^ den_reg[51];
        div_first.ovf   = ({15'd0, num_mag[50:16]} >= den_mag[49:0]);
        div_first.rem   = {15'd0, num_mag[50:16]};
        div_first.dvs   = den_mag[49:0];
        div_first.lo    = num_mag[15:0];
        div_first.quo   = '0;
        div_first.ray   = s2_ray_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_head_reg.valid <= 1'b0;
        end else if (adv) begin
            div_head_reg <= div_first;
        end
    end

    assign div_chain[0] = div_head_reg;

    // The divider: one quotient bit per cell, each cell a pipeline stage.
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rpi_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .d_in    (div_chain[i]),
            .d_out   (div_chain[i + 1])
        );
    end

    // Stage 4: signed saturation of t and the interval test.
    rpi_div_t           dv;
    logic signed [31:0] t_val;
    logic               t_hit;

    assign dv = div_chain[DIV_STEPS];

    always_comb begin
        if (dv.neg) begin
            t_val = (dv.ovf || (dv.quo > 32'h8000_0000)) ? 32'sh8000_0000 : 32'(-dv.quo);
        end else begin
            t_val = (dv.ovf || dv.quo[31]) ? 32'sh7FFF_FFFF : $signed(dv.quo);
        end
        t_hit = dv.ok && (t_val > dv.ray.near_dist) && (t_val <= dv.ray.far_dist);
    end

    logic               s4_valid_reg;
    logic               s4_hit_reg;
    logic signed [31:0] s4_t_reg;
    ray_t               s4_ray_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= dv.valid;
            s4_hit_reg   <= t_hit;
            s4_t_reg     <= t_val;
            s4_ray_reg   <= dv.ray;
        end
    end

    // Stage 5: direction times t for the hit point.
    logic               s5_valid_reg;
    logic               s5_hit_reg;
    logic signed [31:0] s5_t_reg;
    ray_t               s5_ray_reg;
    logic signed [63:0] dt_x_reg, dt_y_reg, dt_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= s4_valid_reg;
            s5_hit_reg   <= s4_hit_reg;
            s5_t_reg     <= s4_t_reg;
            s5_ray_reg   <= s4_ray_reg;
            dt_x_reg     <= s4_ray_reg.dir_x * s4_t_reg;
            dt_y_reg     <= s4_ray_reg.dir_y * s4_t_reg;
            dt_z_reg     <= s4_ray_reg.dir_z * s4_t_reg;
        end
    end

    // Scales a product back to Q16.16, rounding toward zero, adds the origin
    // and clamps the sum to the signed 32-bit range.
    function automatic logic signed [31:0] hit_coord(input logic signed [31:0] org,
                                                     input logic signed [63:0] prod);
        logic signed [47:0] scaled;
        logic signed [48:0] sum;
        scaled = prod[63:16];
        if (prod[63] && (prod[15:0] != 16'd0)) begin
            scaled = scaled + 48'sd1;
        end
        sum = 49'(org) + 49'(scaled);
        if (sum > 49'sh0_7FFF_FFFF) begin
            hit_coord = 32'sh7FFF_FFFF;
        end else if (sum < -49'sh0_8000_0000) begin
            hit_coord = 32'sh8000_0000;
        end else begin
            hit_coord = sum[31:0];
        end
    endfunction

    // Output register: a miss carries all-zero data.
    logic         out_valid_reg;
    logic         out_hit_reg;
    logic [159:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s5_valid_reg;
            out_hit_reg   <= s5_hit_reg;
            if (s5_hit_reg) begin
                out_data_reg <= {colour_reg,
                                 hit_coord(s5_ray_reg.origin_z, dt_z_reg),
                                 hit_coord(s5_ray_reg.origin_y, dt_y_reg),
                                 hit_coord(s5_ray_reg.origin_x, dt_x_reg),
                                 s5_t_reg};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = out_data_reg;

endmodule
